>>> hdl/bhrt_pkg.sv
package bhrt_pkg;

   localparam int MAX_RANGES_DEFAULT = 16;
   localparam int BLOCK_W = 16;
   localparam int REQ_W = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int ENTRY_W = 2 * BLOCK_W;

   typedef enum logic [REQ_W-1:0] {
      REQ_APPEND   = 2'd0,
      REQ_REMOVE   = 2'd1,
      REQ_SET_LAST = 2'd2,
      REQ_CLEAR    = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      AD_IDX,
      AD_IDX_M1,
      AD_IDX_P1,
      AD_POS,
      AD_POS_P1,
      AD_CNT,
      AD_CNT_M1
   } addr_sel_type;

   typedef enum logic [2:0] {
      WD_REQ,
      WD_RD,
      WD_INC_START,
      WD_DEC_END,
      WD_CLIP,
      WD_SPLIT_HI,
      WD_SPLIT_LO
   } wdata_sel_type;

   typedef enum logic [2:0] {
      IX_HOLD,
      IX_CLR,
      IX_INC,
      IX_DEC,
      IX_CNT_M1
   } idx_op_type;

   typedef enum logic [1:0] {
      CN_HOLD,
      CN_INC,
      CN_DEC,
      CN_CLR
   } cnt_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_RM_CHK,
      S_RM_EVAL,
      S_DROP_CHK,
      S_DROP_WR,
      S_UP_CHK,
      S_UP_WR,
      S_SPLIT_LO,
      S_SL_CHK,
      S_SL_EVAL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic          load_req;
      logic          rd_en;
      addr_sel_type  rd_sel;
      logic          wr_en;
      addr_sel_type  wr_sel;
      wdata_sel_type wd_sel;
      logic          cap;
      idx_op_type    idx_op;
      cnt_op_type    cnt_op;
      logic          pos_ld;
      logic          st_ld;
      status_type    st_code;
      logic          rsp_load;
   } cmd_type;

   typedef struct packed {
      req_code_type req_code;
      logic         cnt_zero;
      logic         cnt_full;
      logic         idx_lt_cnt;
      logic         idx_gt_pos;
      logic         rd_s_gt;
      logic         rd_s_eq;
      logic         rd_e_lt;
      logic         rd_e_eq;
      logic         rd_e_gt;
      logic         rd_s_eq_e;
      logic         rsp_hold;
   } flags_type;

endpackage

>>> hdl/block_hole_range_tracker.sv
// Append and clear finish straight from the decode state; remove and set-last walk the table
// entry by entry, so their time grows with the number of intervals held.
// A new request is taken only once the previous one is finished and its result is loaded;
// each table entry a walk visits is read from the RAM and then compared or written.
// A finished result waits in the output register while the next request is taken.
// Synchronous active-high reset empties the table; entries themselves are not cleared.
module block_hole_range_tracker #(
   parameter int MAX_RANGES = bhrt_pkg::MAX_RANGES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bhrt_pkg::REQ_W-1:0]       req_type,
   input  logic [bhrt_pkg::BLOCK_W-1:0]     req_block_a,
   input  logic [bhrt_pkg::BLOCK_W-1:0]     req_block_b,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bhrt_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_next_valid,
   output logic [bhrt_pkg::BLOCK_W-1:0]     rsp_next_block,
   output logic [bhrt_pkg::COUNT_OUT_W-1:0] rsp_interval_count
);

   bhrt_pkg::cmd_type   cmd;
   bhrt_pkg::flags_type flags;

   bhrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   bhrt_dpath #(
      .MAX_RANGES (MAX_RANGES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_type           (req_type),
      .req_block_a        (req_block_a),
      .req_block_b        (req_block_b),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_next_valid     (rsp_next_valid),
      .rsp_next_block     (rsp_next_block),
      .rsp_interval_count (rsp_interval_count),
      .cmd                (cmd),
      .flags              (flags)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_empty_block_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_next_valid |-> rsp_next_block == '0)
      else $error("empty table reported a nonzero first block");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (MAX_RANGES < 32) |-> rsp_next_valid == (rsp_interval_count != '0))
      else $error("interval count disagrees with next valid");

endmodule

>>> hdl/bhrt_ram.sv
module bhrt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bhrt_ctrl.sv
module bhrt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bhrt_pkg::flags_type flags,
   output bhrt_pkg::cmd_type   cmd
);

   bhrt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bhrt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rd_sel = bhrt_pkg::AD_IDX;
      cmd.wr_sel = bhrt_pkg::AD_IDX;
      cmd.wd_sel = bhrt_pkg::WD_REQ;
      cmd.idx_op = bhrt_pkg::IX_HOLD;
      cmd.cnt_op = bhrt_pkg::CN_HOLD;
      cmd.st_code = bhrt_pkg::ST_OK;
      req_ready = 1'b0;
      case (state_ff)
         bhrt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = bhrt_pkg::S_DECODE;
            end
         end
         bhrt_pkg::S_DECODE: begin
            cmd.st_ld = 1'b1;
            cmd.st_code = bhrt_pkg::ST_OK;
            case (flags.req_code)
               bhrt_pkg::REQ_APPEND: begin
                  if (flags.cnt_full) begin
                     cmd.st_code = bhrt_pkg::ST_FULL;
                  end else begin
                     cmd.wr_en = 1'b1;
                     cmd.wr_sel = bhrt_pkg::AD_CNT;
                     cmd.wd_sel = bhrt_pkg::WD_REQ;
                     cmd.cnt_op = bhrt_pkg::CN_INC;
                  end
                  state_in = bhrt_pkg::S_DONE;
               end
               bhrt_pkg::REQ_REMOVE: begin
                  cmd.idx_op = bhrt_pkg::IX_CLR;
                  state_in = bhrt_pkg::S_RM_CHK;
               end
               bhrt_pkg::REQ_SET_LAST: begin
                  state_in = bhrt_pkg::S_SL_CHK;
               end
               default: begin
                  cmd.cnt_op = bhrt_pkg::CN_CLR;
                  state_in = bhrt_pkg::S_DONE;
               end
            endcase
         end
         bhrt_pkg::S_RM_CHK: begin
            if (flags.idx_lt_cnt) begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = bhrt_pkg::AD_IDX;
               state_in = bhrt_pkg::S_RM_EVAL;
            end else begin
               cmd.st_ld = 1'b1;
               cmd.st_code = bhrt_pkg::ST_NOT_FOUND;
               state_in = bhrt_pkg::S_DONE;
            end
         end
         bhrt_pkg::S_RM_EVAL: begin
            cmd.cap = 1'b1;
            if (flags.rd_e_lt) begin
               cmd.idx_op = bhrt_pkg::IX_INC;
               state_in = bhrt_pkg::S_RM_CHK;
            end else if (flags.rd_s_gt) begin
               cmd.st_ld = 1'b1;
               cmd.st_code = bhrt_pkg::ST_NOT_FOUND;
               state_in = bhrt_pkg::S_DONE;
            end else if (flags.rd_s_eq) begin
               if (flags.rd_s_eq_e) begin
                  cmd.idx_op = bhrt_pkg::IX_INC;
                  state_in = bhrt_pkg::S_DROP_CHK;
               end else begin
                  cmd.wr_en = 1'b1;
                  cmd.wr_sel = bhrt_pkg::AD_IDX;
                  cmd.wd_sel = bhrt_pkg::WD_INC_START;
                  state_in = bhrt_pkg::S_DONE;
               end
            end else if (flags.rd_e_eq) begin
               cmd.wr_en = 1'b1;
               cmd.wr_sel = bhrt_pkg::AD_IDX;
               cmd.wd_sel = bhrt_pkg::WD_DEC_END;
               state_in = bhrt_pkg::S_DONE;
            end else if (flags.cnt_full) begin
               cmd.st_ld = 1'b1;
               cmd.st_code = bhrt_pkg::ST_FULL;
               state_in = bhrt_pkg::S_DONE;
            end else begin
               cmd.pos_ld = 1'b1;
               cmd.idx_op = bhrt_pkg::IX_CNT_M1;
               state_in = bhrt_pkg::S_UP_CHK;
            end
         end
         bhrt_pkg::S_DROP_CHK: begin
            if (flags.idx_lt_cnt) begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = bhrt_pkg::AD_IDX;
               state_in = bhrt_pkg::S_DROP_WR;
            end else begin
               cmd.cnt_op = bhrt_pkg::CN_DEC;
               state_in = bhrt_pkg::S_DONE;
            end
         end
         bhrt_pkg::S_DROP_WR: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = bhrt_pkg::AD_IDX_M1;
            cmd.wd_sel = bhrt_pkg::WD_RD;
            cmd.idx_op = bhrt_pkg::IX_INC;
            state_in = bhrt_pkg::S_DROP_CHK;
         end
         bhrt_pkg::S_UP_CHK: begin
            if (flags.idx_gt_pos) begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = bhrt_pkg::AD_IDX;
               state_in = bhrt_pkg::S_UP_WR;
            end else begin
               cmd.wr_en = 1'b1;
               cmd.wr_sel = bhrt_pkg::AD_POS_P1;
               cmd.wd_sel = bhrt_pkg::WD_SPLIT_HI;
               state_in = bhrt_pkg::S_SPLIT_LO;
            end
         end
         bhrt_pkg::S_UP_WR: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = bhrt_pkg::AD_IDX_P1;
            cmd.wd_sel = bhrt_pkg::WD_RD;
            cmd.idx_op = bhrt_pkg::IX_DEC;
            state_in = bhrt_pkg::S_UP_CHK;
         end
         bhrt_pkg::S_SPLIT_LO: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = bhrt_pkg::AD_POS;
            cmd.wd_sel = bhrt_pkg::WD_SPLIT_LO;
            cmd.cnt_op = bhrt_pkg::CN_INC;
            state_in = bhrt_pkg::S_DONE;
         end
         bhrt_pkg::S_SL_CHK: begin
            if (flags.cnt_zero) begin
               state_in = bhrt_pkg::S_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = bhrt_pkg::AD_CNT_M1;
               state_in = bhrt_pkg::S_SL_EVAL;
            end
         end
         bhrt_pkg::S_SL_EVAL: begin
            if (flags.rd_s_gt) begin
               cmd.cnt_op = bhrt_pkg::CN_DEC;
               state_in = bhrt_pkg::S_SL_CHK;
            end else begin
               if (flags.rd_e_gt) begin
                  cmd.wr_en = 1'b1;
                  cmd.wr_sel = bhrt_pkg::AD_CNT_M1;
                  cmd.wd_sel = bhrt_pkg::WD_CLIP;
               end
               state_in = bhrt_pkg::S_DONE;
            end
         end
         bhrt_pkg::S_DONE: begin
            if (!flags.rsp_hold) begin
               cmd.rsp_load = 1'b1;
               state_in = bhrt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bhrt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/bhrt_dpath.sv
module bhrt_dpath #(
   parameter int MAX_RANGES = bhrt_pkg::MAX_RANGES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [bhrt_pkg::REQ_W-1:0]          req_type,
   input  logic [bhrt_pkg::BLOCK_W-1:0]        req_block_a,
   input  logic [bhrt_pkg::BLOCK_W-1:0]        req_block_b,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [bhrt_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_next_valid,
   output logic [bhrt_pkg::BLOCK_W-1:0]        rsp_next_block,
   output logic [bhrt_pkg::COUNT_OUT_W-1:0]    rsp_interval_count,
   input  bhrt_pkg::cmd_type                   cmd,
   output bhrt_pkg::flags_type                 flags
);

   localparam int AW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int BW = bhrt_pkg::BLOCK_W;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff;
   bhrt_pkg::req_code_type code_ff;
   logic [BW-1:0] num_ff;
   logic [BW-1:0] bval_ff;
   logic [BW-1:0] s_ff;
   logic [BW-1:0] e_ff;
   logic [BW-1:0] head_ff;
   bhrt_pkg::status_type status_ff;
   logic rsp_valid_ff;
   logic [bhrt_pkg::STATUS_W-1:0] rsp_status_ff;
   logic rsp_next_valid_ff;
   logic [BW-1:0] rsp_next_block_ff;
   logic [bhrt_pkg::COUNT_OUT_W-1:0] rsp_interval_count_ff;

   logic [bhrt_pkg::ENTRY_W-1:0] rd_data;
   logic [bhrt_pkg::ENTRY_W-1:0] wr_data;
   logic [BW-1:0] rd_s, rd_e;
   logic [CW-1:0] rd_addr_full, wr_addr_full;
   logic [AW-1:0] rd_addr, wr_addr;

   assign rd_s = rd_data[bhrt_pkg::ENTRY_W-1:BW];
   assign rd_e = rd_data[BW-1:0];

   function automatic logic [CW-1:0] pick_addr(
      input bhrt_pkg::addr_sel_type sel,
      input logic [CW-1:0] idx,
      input logic [CW-1:0] pos,
      input logic [CW-1:0] cnt
   );
      logic [CW-1:0] a;
      case (sel)
         bhrt_pkg::AD_IDX:    a = idx;
         bhrt_pkg::AD_IDX_M1: a = idx - CW'(1);
         bhrt_pkg::AD_IDX_P1: a = idx + CW'(1);
         bhrt_pkg::AD_POS:    a = pos;
         bhrt_pkg::AD_POS_P1: a = pos + CW'(1);
         bhrt_pkg::AD_CNT:    a = cnt;
         bhrt_pkg::AD_CNT_M1: a = cnt - CW'(1);
         default:             a = idx;
      endcase
      return a;
   endfunction

   assign rd_addr_full = pick_addr(cmd.rd_sel, idx_ff, pos_ff, count_ff);
   assign wr_addr_full = pick_addr(cmd.wr_sel, idx_ff, pos_ff, count_ff);
   assign rd_addr = rd_addr_full[AW-1:0];
   assign wr_addr = wr_addr_full[AW-1:0];

   always_comb begin
      case (cmd.wd_sel)
         bhrt_pkg::WD_REQ:       wr_data = {num_ff, bval_ff};
         bhrt_pkg::WD_RD:        wr_data = rd_data;
         bhrt_pkg::WD_INC_START: wr_data = {rd_s + BW'(1), rd_e};
         bhrt_pkg::WD_DEC_END:   wr_data = {rd_s, rd_e - BW'(1)};
         bhrt_pkg::WD_CLIP:      wr_data = {rd_s, num_ff};
         bhrt_pkg::WD_SPLIT_HI:  wr_data = {num_ff + BW'(1), e_ff};
         bhrt_pkg::WD_SPLIT_LO:  wr_data = {s_ff, num_ff - BW'(1)};
         default:                wr_data = rd_data;
      endcase
   end

   bhrt_ram #(
      .WIDTH (bhrt_pkg::ENTRY_W),
      .DEPTH (MAX_RANGES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      case (cmd.cnt_op)
         bhrt_pkg::CN_INC: count_in = count_ff + CW'(1);
         bhrt_pkg::CN_DEC: count_in = count_ff - CW'(1);
         bhrt_pkg::CN_CLR: count_in = '0;
         default:          count_in = count_ff;
      endcase
      case (cmd.idx_op)
         bhrt_pkg::IX_CLR:    idx_in = '0;
         bhrt_pkg::IX_INC:    idx_in = idx_ff + CW'(1);
         bhrt_pkg::IX_DEC:    idx_in = idx_ff - CW'(1);
         bhrt_pkg::IX_CNT_M1: idx_in = count_ff - CW'(1);
         default:             idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_req) begin
         code_ff <= bhrt_pkg::req_code_type'(req_type);
         num_ff <= req_block_a;
         bval_ff <= req_block_b;
      end
      if (cmd.pos_ld) begin
         pos_ff <= idx_ff;
      end
      if (cmd.cap) begin
         s_ff <= rd_s;
         e_ff <= rd_e;
      end
      if (cmd.wr_en && (wr_addr_full == '0)) begin
         head_ff <= wr_data[bhrt_pkg::ENTRY_W-1:BW];
      end
      if (cmd.st_ld) begin
         status_ff <= cmd.st_code;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_next_valid_ff <= (count_ff != '0);
         rsp_next_block_ff <= (count_ff != '0) ? head_ff : '0;
         rsp_interval_count_ff <= bhrt_pkg::COUNT_OUT_W'(count_ff);
      end
   end

   assign flags.req_code = code_ff;
   assign flags.cnt_zero = (count_ff == '0);
   assign flags.cnt_full = (count_ff >= CW'(MAX_RANGES));
   assign flags.idx_lt_cnt = (idx_ff < count_ff);
   assign flags.idx_gt_pos = (idx_ff > pos_ff);
   assign flags.rd_s_gt = (rd_s > num_ff);
   assign flags.rd_s_eq = (rd_s == num_ff);
   assign flags.rd_e_lt = (rd_e < num_ff);
   assign flags.rd_e_eq = (rd_e == num_ff);
   assign flags.rd_e_gt = (rd_e > num_ff);
   assign flags.rd_s_eq_e = (rd_s == rd_e);
   assign flags.rsp_hold = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_next_valid = rsp_next_valid_ff;
   assign rsp_next_block = rsp_next_block_ff;
   assign rsp_interval_count = rsp_interval_count_ff;

endmodule

>>> test/block_hole_range_tracker_tb.sv
module block_hole_range_tracker_tb;

   localparam int TABLE_DEPTH = bhrt_pkg::MAX_RANGES_DEFAULT;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 4 * TABLE_DEPTH + 40;

   typedef struct {
      bhrt_pkg::req_code_type code;
      logic [bhrt_pkg::BLOCK_W-1:0] a;
      logic [bhrt_pkg::BLOCK_W-1:0] b;
      bit drain_first;
   } hole_req_type;

   typedef struct {
      bhrt_pkg::status_type st;
      logic nv;
      logic [bhrt_pkg::BLOCK_W-1:0] nb;
      logic [bhrt_pkg::COUNT_OUT_W-1:0] cnt;
   } hole_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [bhrt_pkg::REQ_W-1:0] req_type = '0;
   logic [bhrt_pkg::BLOCK_W-1:0] req_block_a = '0;
   logic [bhrt_pkg::BLOCK_W-1:0] req_block_b = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [bhrt_pkg::STATUS_W-1:0] rsp_status;
   logic rsp_next_valid;
   logic [bhrt_pkg::BLOCK_W-1:0] rsp_next_block;
   logic [bhrt_pkg::COUNT_OUT_W-1:0] rsp_interval_count;

   hole_req_type req_backlog[$];
   hole_report_type expected_reports[$];
   hole_req_type in_flight;
   int reqs_queued = 0;
   int err_n = 0;
   int cycle_n = 0;

   logic [bhrt_pkg::BLOCK_W-1:0] hole_lo[TABLE_DEPTH];
   logic [bhrt_pkg::BLOCK_W-1:0] hole_hi[TABLE_DEPTH];
   int holes_held = 0;

   block_hole_range_tracker #(.MAX_RANGES(TABLE_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_block_a(req_block_a),
      .req_block_b(req_block_b),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_next_valid(rsp_next_valid),
      .rsp_next_block(rsp_next_block),
      .rsp_interval_count(rsp_interval_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one request to the hole table and returns the report it produces.
   function automatic hole_report_type apply_hole_request(hole_req_type r);
      hole_report_type rep;
      bhrt_pkg::status_type st;
      int i;
      int k;
      bit done;
      st = bhrt_pkg::ST_OK;
      done = 1'b0;
      case (r.code)
         bhrt_pkg::REQ_APPEND: begin
            if (holes_held >= TABLE_DEPTH) begin
               st = bhrt_pkg::ST_FULL;
            end else begin
               hole_lo[holes_held] = r.a;
               hole_hi[holes_held] = r.b;
               holes_held++;
            end
         end
         bhrt_pkg::REQ_REMOVE: begin
            st = bhrt_pkg::ST_NOT_FOUND;
            for (i = 0; i < holes_held; i++) begin
               if (!done && hole_hi[i] >= r.a) begin
                  done = 1'b1;
                  if (hole_lo[i] > r.a) begin
                     st = bhrt_pkg::ST_NOT_FOUND;
                  end else if (hole_lo[i] == r.a) begin
                     st = bhrt_pkg::ST_OK;
                     if (hole_lo[i] == hole_hi[i]) begin
                        for (k = i; k + 1 < holes_held; k++) begin
                           hole_lo[k] = hole_lo[k+1];
                           hole_hi[k] = hole_hi[k+1];
                        end
                        holes_held--;
                     end else begin
                        hole_lo[i] = hole_lo[i] + 16'd1;
                     end
                  end else if (hole_hi[i] == r.a) begin
                     st = bhrt_pkg::ST_OK;
                     hole_hi[i] = hole_hi[i] - 16'd1;
                  end else if (holes_held >= TABLE_DEPTH) begin
                     st = bhrt_pkg::ST_FULL;
                  end else begin
                     st = bhrt_pkg::ST_OK;
                     for (k = holes_held; k > i + 1; k--) begin
                        hole_lo[k] = hole_lo[k-1];
                        hole_hi[k] = hole_hi[k-1];
                     end
                     hole_lo[i+1] = r.a + 16'd1;
                     hole_hi[i+1] = hole_hi[i];
                     hole_hi[i] = r.a - 16'd1;
                     holes_held++;
                  end
               end
            end
         end
         bhrt_pkg::REQ_SET_LAST: begin
            while (holes_held > 0 && !done) begin
               if (hole_lo[holes_held-1] > r.a) begin
                  holes_held--;
               end else begin
                  if (hole_hi[holes_held-1] > r.a) begin
                     hole_hi[holes_held-1] = r.a;
                  end
                  done = 1'b1;
               end
            end
         end
         default: begin
            holes_held = 0;
         end
      endcase
      rep.st = st;
      rep.nv = (holes_held > 0);
      rep.nb = (holes_held > 0) ? hole_lo[0] : '0;
      rep.cnt = holes_held[bhrt_pkg::COUNT_OUT_W-1:0];
      return rep;
   endfunction

   task automatic queue_req(bhrt_pkg::req_code_type code, int a, int b, bit drain);
      hole_req_type r;
      r.code = code;
      r.a = a[bhrt_pkg::BLOCK_W-1:0];
      r.b = b[bhrt_pkg::BLOCK_W-1:0];
      r.drain_first = drain;
      req_backlog.push_back(r);
      reqs_queued++;
   endtask

   // Builds an ordered hole list, then removes, clips and extends it.
   task automatic hole_scenario();
      int n;
      int i;
      int pick;
      int cursor;
      int span_lo;
      int lo;
      int hi;
      int ops;
      queue_req(bhrt_pkg::REQ_CLEAR, $urandom, $urandom, ($urandom_range(0, 7) == 0));
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 14);
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         cursor = 0;
      end else if (pick == 1) begin
         cursor = 65535 - $urandom_range(0, 120);
      end else begin
         cursor = $urandom_range(0, 60000);
      end
      span_lo = cursor;
      for (i = 0; i < n; i++) begin
         lo = cursor + $urandom_range(0, 3);
         if (lo <= 65535) begin
            hi = lo + $urandom_range(0, 6);
            if (hi > 65535) begin
               hi = 65535;
            end
            queue_req(bhrt_pkg::REQ_APPEND, lo, hi, 1'b0);
            cursor = hi + 1;
         end
      end
      ops = $urandom_range(4, 30);
      for (i = 0; i < ops; i++) begin
         pick = $urandom_range(0, 19);
         lo = cursor + $urandom_range(0, 3);
         if (pick >= 17 && pick < 19 && lo <= 65535) begin
            hi = lo + $urandom_range(0, 6);
            if (hi > 65535) begin
               hi = 65535;
            end
            queue_req(bhrt_pkg::REQ_APPEND, lo, hi, 1'b0);
            cursor = hi + 1;
         end else if (pick == 19) begin
            queue_req(bhrt_pkg::req_code_type'($urandom_range(0, 3)), $urandom, $urandom,
                      1'b0);
         end else if (pick >= 15 && pick < 17) begin
            queue_req(bhrt_pkg::REQ_SET_LAST,
                      $urandom_range(span_lo, (cursor > 65535) ? 65535 : cursor),
                      $urandom, 1'b0);
         end else begin
            queue_req(bhrt_pkg::REQ_REMOVE,
                      $urandom_range(span_lo, (cursor + 1 > 65535) ? 65535 : cursor + 1),
                      $urandom, 1'b0);
         end
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      static int burst_left = 0;
      static int gap_left = 0;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_reports.push_back(apply_hole_request(in_flight));
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0 &&
                         !(req_backlog[0].drain_first && expected_reports.size() != 0)) begin
               in_flight = req_backlog.pop_front();
               req_type <= in_flight.code;
               req_block_a <= in_flight.a;
               req_block_b <= in_flight.b;
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stalls follow a pattern that changes now and then, with one long hold-off.
   always @(posedge clock) begin
      static int rx_cycles = 0;
      static int mode = 0;
      static int mode_left = 0;
      static int holdoff_left = 0;
      static bit holdoff_done = 1'b0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycles++;
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else if (!holdoff_done && rx_cycles >= 4000) begin
            holdoff_left = 600;
            holdoff_done = 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end else begin
               mode_left--;
            end
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= (rx_cycles % 4) != 0;
               default: rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      hole_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected transfer, got status %0d next %0d/%0d count %0d",
                     $time, rsp_status, rsp_next_valid, rsp_next_block, rsp_interval_count);
            err_n++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_status !== want.st || rsp_next_valid !== want.nv ||
                rsp_next_block !== want.nb || rsp_interval_count !== want.cnt) begin
               $display("%0t: expected status %0d next %0d/%0d count %0d, got %0d %0d/%0d %0d",
                        $time, want.st, want.nv, want.nb, want.cnt, rsp_status,
                        rsp_next_valid, rsp_next_block, rsp_interval_count);
               err_n++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_n++;
      if (cycle_n > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int directed_n;
      queue_req(bhrt_pkg::REQ_REMOVE, 5, 65535, 1'b0);
      queue_req(bhrt_pkg::REQ_SET_LAST, 100, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_APPEND, 10, 20, 1'b0);
      queue_req(bhrt_pkg::REQ_APPEND, 30, 30, 1'b0);
      queue_req(bhrt_pkg::REQ_APPEND, 40, 50, 1'b0);
      queue_req(bhrt_pkg::REQ_APPEND, 65535, 65535, 1'b0);
      queue_req(bhrt_pkg::REQ_REMOVE, 10, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_REMOVE, 20, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_REMOVE, 15, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_REMOVE, 15, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_REMOVE, 30, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_REMOVE, 65535, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_REMOVE, 60000, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_SET_LAST, 45, 65535, 1'b0);
      queue_req(bhrt_pkg::REQ_SET_LAST, 12, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_CLEAR, 65535, 65535, 1'b0);
      queue_req(bhrt_pkg::REQ_APPEND, 500, 400, 1'b0);
      queue_req(bhrt_pkg::REQ_REMOVE, 450, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_SET_LAST, 10, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_APPEND, 0, 65535, 1'b0);
      queue_req(bhrt_pkg::REQ_REMOVE, 0, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_REMOVE, 65535, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_SET_LAST, 0, 0, 1'b0);
      queue_req(bhrt_pkg::REQ_CLEAR, 0, 0, 1'b0);
      directed_n = reqs_queued;
      while (reqs_queued - directed_n < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) < 17) begin
            hole_scenario();
         end else begin
            repeat ($urandom_range(1, 6)) begin
               queue_req(bhrt_pkg::req_code_type'($urandom_range(0, 3)), $urandom, $urandom,
                         1'b0);
            end
         end
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_n == 0 && expected_reports.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/bhrt_pkg.sv
hdl/bhrt_ram.sv
hdl/bhrt_ctrl.sv
hdl/bhrt_dpath.sv
hdl/block_hole_range_tracker.sv
test/block_hole_range_tracker_tb.sv
